### rtl/gnn_pkg.sv
`default_nettype none
package gnn_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COORD_W        = 12;
  localparam int unsigned SQ_W           = 24;  // largest square of a 13-bit delta
  localparam int unsigned DIST_W         = 25;
  localparam int unsigned ID_W           = 10;
  localparam int unsigned PIDX_W         = 6;
  localparam int unsigned CMP_W          = 7;
  localparam int unsigned IN_W           = 32;
  localparam int unsigned OUT_W          = 16;

  localparam logic [ID_W-1:0] ID_MAX = 10'd1023;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_SCAN
  } gnn_state_t;

  // candidate point entering the distance pipe
  typedef struct packed {
    logic                      vld;
    logic [PIDX_W-1:0]         idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  // candidate point with its squared deltas
  typedef struct packed {
    logic                      vld;
    logic [PIDX_W-1:0]         idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SQ_W-1:0]           sqx;
    logic [SQ_W-1:0]           sqy;
  } sq_t;

endpackage
`default_nettype wire

### rtl/gnn_dist.sv
`default_nettype none
module gnn_dist
  import gnn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [COORD_W-1:0] cur_x,
  input  logic signed [COORD_W-1:0] cur_y,
  input  pt_t                       pt_i,
  output sq_t                       sq_o
);

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] px;
  logic signed [2*COORD_W+1:0] py;
  sq_t                         sq_r;

  assign dx = (COORD_W+1)'(pt_i.x) - (COORD_W+1)'(cur_x);
  assign dy = (COORD_W+1)'(pt_i.y) - (COORD_W+1)'(cur_y);
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.vld <= 1'b0;
    end else begin
      sq_r.vld <= pt_i.vld;
    end
    sq_r.idx <= pt_i.idx;
    sq_r.x   <= pt_i.x;
    sq_r.y   <= pt_i.y;
    sq_r.sqx <= px[SQ_W-1:0];
    sq_r.sqy <= py[SQ_W-1:0];
  end

  assign sq_o = sq_r;

endmodule
`default_nettype wire

### rtl/greedy_nearest_neighbor_order.sv
`default_nettype none
// Greedy nearest-neighbor ordering. Load words store 2-D points in order into
// a point memory; a run word starting at a loaded point emits every loaded point
// once, each next one being the untaken point nearest to the previous by squared
// distance (ties to the lowest load index), tagged with a running order ID that
// saturates at 1023 and is reset by a clear word. A run empties the set; a run
// whose start index is not below the point count does nothing. A run's length
// is set by the single read port of the point memory, which is swept once, one
// entry a cycle, for every point after the first. No input is taken during a run.
module greedy_nearest_neighbor_order
  import gnn_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // op[1:0], x[13:2], y[25:14], start_index[31:26]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // point_index[5:0], order_id[15:6]
  output logic             out_tlast
);

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  gnn_state_t state_r, state_nxt;

  op_t                       in_op;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic [PIDX_W-1:0]         in_start;
  logic                      in_acc;
  logic                      start_ok;
  logic                      out_free;

  logic run_go, load_we, clr_id, emit_go, issue, scan_done;
  logic [IDX_W-1:0] rd_addr;

  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [CNT_W-1:0]     rd_cnt_r;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      remain_r;
  logic [ID_W-1:0]       next_id_r;
  logic [MAX_POINTS-1:0] taken_r;

  logic signed [COORD_W-1:0] cur_x_r, cur_y_r;
  logic signed [COORD_W-1:0] pick_x_r, pick_y_r;
  logic [IDX_W-1:0]          pick_idx_r;

  logic                      best_vld_r;
  logic [DIST_W-1:0]         best_dist_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic signed [COORD_W-1:0] best_x_r, best_y_r;

  logic              out_vld_r;
  logic [PIDX_W-1:0] out_pidx_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_last_r;

  pt_t               pt;
  sq_t               sq;
  logic [DIST_W-1:0] cand_dist;
  logic              better;

  assign in_op    = op_t'(in_tdata[1:0]);
  assign in_x     = in_tdata[13:2];
  assign in_y     = in_tdata[25:14];
  assign in_start = in_tdata[31:26];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign start_ok = CMP_W'(in_start) < CMP_W'(count_r);
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_RUN) && start_ok) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = (remain_r == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    run_go    = 1'b0;
    load_we   = 1'b0;
    clr_id    = 1'b0;
    emit_go   = 1'b0;
    issue     = 1'b0;
    scan_done = 1'b0;
    rd_addr   = rd_cnt_r[IDX_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = in_start[IDX_W-1:0];
        if (in_acc) begin
          case (in_op)
            OP_LOAD:  load_we = (count_r != CNT_W'(MAX_POINTS));
            OP_RUN:   run_go  = start_ok;
            OP_CLEAR: clr_id  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FETCH: ;
      ST_EMIT: begin
        emit_go = out_free;
      end
      ST_SCAN: begin
        issue     = (rd_cnt_r != count_r);
        scan_done = !issue && !rd_vld_r && !sq.vld;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // point memory: write on load, one registered read a cycle
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[count_r[IDX_W-1:0]] <= {in_y, in_x};
    end
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= rd_cnt_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_cnt_r <= '0;
    end else begin
      rd_vld_r <= issue;
      if (emit_go) begin
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
    end
  end

  // drop taken points before the distance pipe
  always_comb begin
    pt.vld = rd_vld_r && !taken_r[rd_idx_r];
    pt.idx = PIDX_W'(rd_idx_r);
    pt.x   = rd_data_r[COORD_W-1:0];
    pt.y   = rd_data_r[2*COORD_W-1:COORD_W];
  end

  gnn_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .cur_x (cur_x_r),
    .cur_y (cur_y_r),
    .pt_i  (pt),
    .sq_o  (sq)
  );

  assign cand_dist = DIST_W'(sq.sqx) + DIST_W'(sq.sqy);
  assign better    = sq.vld && (!best_vld_r || (cand_dist < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (emit_go) begin
      best_vld_r <= 1'b0;
    end else if (better) begin
      best_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_dist_r <= cand_dist;
      best_idx_r  <= sq.idx[IDX_W-1:0];
      best_x_r    <= sq.x;
      best_y_r    <= sq.y;
    end
  end

  always_ff @(posedge clk) begin
    if (run_go) begin
      pick_idx_r <= in_start[IDX_W-1:0];
    end else if (state_r == ST_FETCH) begin
      pick_x_r <= rd_data_r[COORD_W-1:0];
      pick_y_r <= rd_data_r[2*COORD_W-1:COORD_W];
    end else if (scan_done) begin
      pick_idx_r <= best_idx_r;
      pick_x_r   <= best_x_r;
      pick_y_r   <= best_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      remain_r  <= '0;
      next_id_r <= '0;
      taken_r   <= '0;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
    end else begin
      if (load_we) begin
        count_r <= count_r + 1'b1;
      end
      if (clr_id) begin
        next_id_r <= '0;
      end
      if (run_go) begin
        remain_r <= count_r - 1'b1;
        taken_r  <= '0;
      end
      if (emit_go) begin
        cur_x_r <= pick_x_r;
        cur_y_r <= pick_y_r;
        if (next_id_r != ID_MAX) begin
          next_id_r <= next_id_r + 1'b1;
        end
        if (remain_r == '0) begin
          // run over: empty the set
          count_r <= '0;
          taken_r <= '0;
        end else begin
          remain_r            <= remain_r - 1'b1;
          taken_r[pick_idx_r] <= 1'b1;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_go) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_pidx_r <= PIDX_W'(pick_idx_r);
      out_id_r   <= next_id_r;
      out_last_r <= (remain_r == '0);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_id_r, out_pidx_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

### rtl/gnn_checker.sv
`default_nettype none
module gnn_checker
  import gnn_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic [IN_W-1:0]  in_tdata,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             out_tlast
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // the input stays ready after a load or clear
  a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] != OP_RUN) |=> in_tready)
    else $error("input stalled after a load or clear");

  // a point that is not the last of a run means the scan goes on
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && !out_tlast |-> !in_tready)
    else $error("input taken in the middle of a run");

endmodule

bind greedy_nearest_neighbor_order gnn_checker u_gnn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
